/* src/css_pkg.sv */
`default_nettype none
package css_pkg;

    localparam int DEPTH      = 16;
    localparam int WORD_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int IDX_W      = $clog2(DEPTH);

    typedef logic [WORD_WIDTH-1:0] word_t;
    typedef logic [CNT_W-1:0]      count_t;

    localparam logic [2:0] ACT_START   = 3'd0;
    localparam logic [2:0] ACT_ADVANCE = 3'd1;
    localparam logic [2:0] ACT_INSERT  = 3'd2;
    localparam logic [2:0] ACT_ATTACH  = 3'd3;
    localparam logic [2:0] ACT_REMOVE  = 3'd4;
    localparam logic [2:0] ACT_READ    = 3'd5;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_NOCUR = 2'd2;

    // per-cell move control; take_new wins over the shifts
    typedef struct packed {
        logic take_new;
        logic take_prev;
        logic take_next;
    } cell_ctrl_t;

endpackage
`default_nettype wire

/* src/css_cell.sv */
`default_nettype none
module css_cell (
    input  wire                      clk,
    input  wire css_pkg::cell_ctrl_t ctrl,
    input  wire css_pkg::word_t      new_word,
    input  wire css_pkg::word_t      prev_word,
    input  wire css_pkg::word_t      next_word,
    output css_pkg::word_t           word_next,
    output css_pkg::word_t           word_q
);
    import css_pkg::*;

    word_t word_reg;

    always_comb
    begin
        if (ctrl.take_new)
            word_next = new_word;
        else if (ctrl.take_prev)
            word_next = prev_word;
        else if (ctrl.take_next)
            word_next = next_word;
        else
            word_next = word_reg;
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word_q = word_reg;

endmodule
`default_nettype wire

/* src/cursor_sequence_store.sv */
`default_nettype none
// Ordered store of up to DEPTH words with a cursor, built as a row of cells.
//
// Input channel: action and entry_word, taken when in_valid is high and
// in_stall is low. Output channel: has_current, current_word, item_count and
// status, taken when out_valid is high and out_stall is low. Every input
// item gives exactly one result item.
//
// The result of an item is written to the output register at the clock edge
// that takes the item. Throughput is one item per cycle while out_stall is low;
// it is set by the row of cells, whose words at and beyond the position all move
// in the same cycle on insert, attach and remove.
//
// Reset empties the store (count and cursor to zero) and drops any pending
// result. The cell words are not cleared; only stored positions are read.
//
// While the receiver stalls a waiting result, the result is held and in_stall
// is raised, so no new item is taken until the result has gone.
module cursor_sequence_store (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [2:0]  action,
    input  wire  [31:0] entry_word,
    output logic        out_valid,
    input  wire         out_stall,
    output logic        has_current,
    output logic [31:0] current_word,
    output logic [4:0]  item_count,
    output logic [1:0]  status
);
    import css_pkg::*;

    count_t     count_reg, count_next;
    count_t     cursor_reg, cursor_next;
    count_t     pos;
    logic       accept;
    logic       place, drop;
    logic [1:0] status_next;
    word_t      new_word;
    word_t      cur_word_next;

    cell_ctrl_t ctrl      [DEPTH];
    word_t      cell_q    [DEPTH];
    word_t      cell_next [DEPTH];

    logic        out_valid_reg;
    logic        has_cur_reg;
    logic [31:0] cur_word_reg;
    logic [4:0]  count_out_reg;
    logic [1:0]  status_reg;

    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;
    assign new_word = word_t'(entry_word);

    always_comb
    begin
        count_next  = count_reg;
        cursor_next = cursor_reg;
        status_next = ST_DONE;
        pos         = '0;
        place       = 1'b0;
        drop        = 1'b0;
        case (action)
            ACT_START:
            begin
                cursor_next = (count_reg != '0) ? count_t'(1) : '0;
            end
            ACT_ADVANCE:
            begin
                if (cursor_reg != '0)
                    cursor_next = (cursor_reg == count_reg) ? '0 : cursor_reg + count_t'(1);
            end
            ACT_INSERT, ACT_ATTACH:
            begin
                if (action == ACT_INSERT)
                    pos = (cursor_reg != '0) ? cursor_reg - count_t'(1) : '0;
                else
                    pos = (cursor_reg != '0) ? cursor_reg : count_reg;
                if (count_reg == count_t'(DEPTH))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    place       = 1'b1;
                    count_next  = count_reg + count_t'(1);
                    cursor_next = pos + count_t'(1);
                end
            end
            ACT_REMOVE:
            begin
                if (cursor_reg == '0)
                begin
                    status_next = ST_NOCUR;
                end
                else
                begin
                    drop        = 1'b1;
                    pos         = cursor_reg - count_t'(1);
                    count_next  = count_reg - count_t'(1);
                    // the following item takes the cursor's place
                    cursor_next = (cursor_reg < count_reg) ? cursor_reg : '0;
                end
            end
            default:
            begin
                // read, and the unused codes
            end
        endcase
    end

    // open a gap at pos for the new word, or close the one at pos
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ctrl[i].take_new  = accept & place & (count_t'(i) == pos);
            ctrl[i].take_prev = accept & place & (count_t'(i) > pos);
            ctrl[i].take_next = accept & drop & (count_t'(i) >= pos) && (i != DEPTH - 1);
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            word_t prev_w, next_w;
            if (g == 0)
            begin : g_lo
                assign prev_w = new_word;
            end
            else
            begin : g_lo
                assign prev_w = cell_q[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_hi
                assign next_w = cell_q[g];
            end
            else
            begin : g_hi
                assign next_w = cell_q[g+1];
            end
            css_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl[g]),
                .new_word  (new_word),
                .prev_word (prev_w),
                .next_word (next_w),
                .word_next (cell_next[g]),
                .word_q    (cell_q[g])
            );
        end
    endgenerate

    always_comb
    begin
        count_t sel;
        sel           = cursor_next - count_t'(1);
        cur_word_next = (cursor_next != '0) ? cell_next[sel[IDX_W-1:0]] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                cursor_reg    <= cursor_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            has_cur_reg   <= (cursor_next != '0);
            cur_word_reg  <= 32'(cur_word_next);
            count_out_reg <= 5'(count_next);
            status_reg    <= status_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign has_current  = has_cur_reg;
    assign current_word = cur_word_reg;
    assign item_count   = count_out_reg;
    assign status       = status_reg;

endmodule
`default_nettype wire

/* src/css_checker.sv */
`default_nettype none
module css_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        in_valid,
    input wire        in_stall,
    input wire        out_valid,
    input wire        out_stall,
    input wire        has_current,
    input wire [31:0] current_word,
    input wire [4:0]  item_count,
    input wire [1:0]  status
);
    import css_pkg::*;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (item_count <= 5'(DEPTH)))
        else $error("item count beyond depth");

    a_no_cur_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !has_current) |-> (current_word == 32'd0))
        else $error("word reported with no current item");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FULL) |-> (item_count == 5'(DEPTH)))
        else $error("full flag on a store that is not full");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && in_valid && !in_stall)
            |=> (out_valid && (item_count - $past(item_count) == 5'd1
                || $past(item_count) - item_count == 5'd1
                || item_count == $past(item_count))))
        else $error("item count moved by more than one");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
        else $error("accepted item gave no result");

endmodule

bind cursor_sequence_store css_checker u_css_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .has_current  (has_current),
    .current_word (current_word),
    .item_count   (item_count),
    .status       (status)
);
`default_nettype wire
